// ===== rtl/hnm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the heightmap normal-map block.
// No dependencies; used by hnm_unit and heightmap_normal_map_top.
package hnm_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_HEIGHT_SCALE = 3'd2;
    localparam logic [2:0] REG_SPACING_X    = 3'd3;
    localparam logic [2:0] REG_SPACING_Y    = 3'd4;

    // Request to the slope normalizer: slope (p-q)*scale against spacing
    typedef struct packed {
        logic        start;
        logic [15:0] p;
        logic [15:0] q;
        logic [15:0] scale;
        logic [15:0] spacing;
    } hnm_req_t;

    // Unit vector in Q1.30
    typedef struct packed {
        logic               done;
        logic signed [31:0] along;
        logic        [31:0] up;
    } hnm_rsp_t;

endpackage

// ===== rtl/hnm_unit.sv =====
`timescale 1ns / 1ps
// Iterative slope normalizer: scale, normalize, square root, two divisions.
// Depends on hnm_pkg.
module hnm_unit
    import hnm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  hnm_req_t req,
    output hnm_rsp_t rsp
);

    typedef enum logic [7:0] {
        U_IDLE = 8'b0000_0001,
        U_MUL  = 8'b0000_0010,
        U_NORM = 8'b0000_0100,
        U_SQA  = 8'b0000_1000,
        U_SQB  = 8'b0001_0000,
        U_ROOT = 8'b0010_0000,
        U_DIV  = 8'b0100_0000,
        U_DONE = 8'b1000_0000
    } ustate_t;

    ustate_t     state_reg, state_next;
    logic        neg_reg;
    logic [15:0] mag_reg;
    logic [15:0] scale_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [63:0] sq_reg;
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [31:0] len_reg;
    logic [31:0] rema_reg;
    logic [31:0] remb_reg;
    logic [30:0] qa_reg;
    logic [30:0] qb_reg;
    logic [4:0]  cnt_reg;
    logic        first_reg;

    logic signed [16:0] diff;
    logic [15:0]        sp_eff;
    logic [31:0]        mul_x, mul_y;
    logic [63:0]        prod;
    logic [31:0]        m;
    logic [63:0]        root_sum;
    logic               root_ge;
    logic [32:0]        ta, tb;
    logic               ga, gb;

    function automatic logic signed [16:0] p_sx(input logic [15:0] v);
        p_sx = {v[15], v};
    endfunction

    // Slope difference and its magnitude
    assign diff   = {p_sx(req.p)} - {p_sx(req.q)};
    assign sp_eff = (req.spacing == 16'd0) ? 16'd1 : req.spacing;

    // Share one multiplier across scale and squares
    always_comb
    begin
        unique case (state_reg)
            U_MUL:
            begin
                mul_x = {16'd0, mag_reg};
                mul_y = {16'd0, scale_reg};
            end
            U_SQA:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            default:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
            end
        endcase
    end
    assign prod = mul_x * mul_y;

    assign m        = (a_reg > b_reg) ? a_reg : b_reg;
    assign root_sum = r_reg + bit_reg;
    assign root_ge  = v_reg >= root_sum;

    // One quotient bit per cycle for each component
    assign ta = first_reg ? {1'b0, rema_reg} : {rema_reg, 1'b0};
    assign tb = first_reg ? {1'b0, remb_reg} : {remb_reg, 1'b0};
    assign ga = ta >= {1'b0, len_reg};
    assign gb = tb >= {1'b0, len_reg};

    // Sequence control
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE: if (req.start) state_next = U_MUL;
            U_MUL:  state_next = U_NORM;
            U_NORM: if (m[31] || m[30]) state_next = U_SQA;
            U_SQA:  state_next = U_SQB;
            U_SQB:  state_next = U_ROOT;
            U_ROOT: if (cnt_reg == 5'd0) state_next = U_DIV;
            U_DIV:  if (cnt_reg == 5'd0) state_next = U_DONE;
            U_DONE: state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= U_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                neg_reg   <= diff[16];
                mag_reg   <= diff[16] ? 16'(-diff) : diff[15:0];
                scale_reg <= req.scale;
                b_reg     <= {8'd0, sp_eff, 8'd0};
            end
            U_MUL:
                a_reg <= prod[31:0];
            U_NORM:
            begin
                if (m[31])
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                end
                else if (!m[30])
                begin
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg << 1;
                end
            end
            U_SQA:
                sq_reg <= prod;
            U_SQB:
            begin
                v_reg   <= sq_reg + prod;
                r_reg   <= 64'd0;
                bit_reg <= 64'd1 << 62;
                cnt_reg <= 5'd31;
            end
            U_ROOT:
            begin
                if (root_ge)
                begin
                    v_reg <= v_reg - root_sum;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == 5'd0)
                begin
                    len_reg   <= root_ge ? 32'((r_reg >> 1) + bit_reg) : 32'(r_reg >> 1);
                    rema_reg  <= a_reg;
                    remb_reg  <= b_reg;
                    qa_reg    <= 31'd0;
                    qb_reg    <= 31'd0;
                    cnt_reg   <= 5'd30;
                    first_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            U_DIV:
            begin
                rema_reg  <= ga ? 32'(ta - {1'b0, len_reg}) : ta[31:0];
                remb_reg  <= gb ? 32'(tb - {1'b0, len_reg}) : tb[31:0];
                qa_reg    <= {qa_reg[29:0], ga};
                qb_reg    <= {qb_reg[29:0], gb};
                first_reg <= 1'b0;
                cnt_reg   <= cnt_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done  = (state_reg == U_DONE);
    assign rsp.along = neg_reg ? -$signed({1'b0, qa_reg}) : $signed({1'b0, qa_reg});
    assign rsp.up    = {1'b0, qb_reg};

endmodule

// ===== rtl/heightmap_normal_map_top.sv =====
`timescale 1ns / 1ps
// Heightmap to normal-map converter: line stores, sequencer and output beat.
// Depends on hnm_pkg and hnm_unit.
//
// Usage: heightmap samples (signed Q7.8) enter in raster order on the in_*
// channel; normals leave on the out_* channel as bytes with their pixel
// coordinates. Pixel (x,y-1) is produced by sample (x,y); the final row is
// produced during its own arrival, so one sample gives zero to three beats.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// One item is worked at a time. Each normal needs four slope vectors, each
// run through one shared normalizer in 1 to 23 normalize steps, 32 root
// steps and 31 divide steps.
// A finished beat waits in the output register; while the receiver stalls,
// the next beat of the same item waits for it, and the block stays busy.
// Reset clears counters and control and loads the register defaults;
// line-store contents are undefined until written.
module heightmap_normal_map_top
    import hnm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [15:0]           height_sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   normal_x_byte,
    output logic [7:0]                   normal_y_byte,
    output logic [7:0]                   normal_z_byte,
    output logic [$clog2(MAX_WIDTH)-1:0] pixel_column,
    output logic [15:0]                  pixel_row,
    output logic                         last_of_run,
    output logic                         image_done
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WD_W > 11) ? WD_W + 1 : 12;
    localparam logic [41:0] BYTE_BIAS = 42'h80_0000_0000;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b0_0000_0001,
        ST_RD0    = 9'b0_0000_0010,
        ST_RD1    = 9'b0_0000_0100,
        ST_RD2    = 9'b0_0000_1000,
        ST_RD3    = 9'b0_0001_0000,
        ST_LAUNCH = 9'b0_0010_0000,
        ST_WAIT   = 9'b0_0100_0000,
        ST_EMIT   = 9'b0_1000_0000,
        ST_FIN    = 9'b1_0000_0000
    } state_t;

    // Configuration
    logic [10:0] cfg_width_reg;
    logic [15:0] cfg_height_reg;
    logic [15:0] cfg_scale_reg;
    logic [15:0] cfg_spx_reg;
    logic [15:0] cfg_spy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= 11'd1024;
            cfg_height_reg <= 16'd1024;
            cfg_scale_reg  <= 16'd256;
            cfg_spx_reg    <= 16'd256;
            cfg_spy_reg    <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_data[10:0];
                REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_data;
                REG_HEIGHT_SCALE: cfg_scale_reg  <= cfg_data;
                REG_SPACING_X:    cfg_spx_reg    <= cfg_data;
                REG_SPACING_Y:    cfg_spy_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Control and state registers
    state_t             state_reg, state_next;
    logic               sel_reg;
    logic [COL_W-1:0]   col_reg;
    logic [15:0]        row_reg;
    logic [15:0]        prev_reg;
    logic [15:0]        prev2_reg;
    logic [15:0]        cur_reg;
    logic [2:0]         mask_reg;
    logic [1:0]         vec_reg;
    logic               out_valid_reg;

    // Payload registers
    logic [15:0]        rdx_reg, rdxm_reg, rdxp_reg, wrx_reg;
    logic signed [33:0] ax_reg, ay_reg, az_reg;
    logic [7:0]         nx_reg, ny_reg, nz_reg;
    logic [COL_W-1:0]   ocol_reg;
    logic [15:0]        orow_reg;
    logic               olast_reg, odone_reg;

    // Line stores
    logic [15:0]        store_a [MAX_WIDTH];
    logic [15:0]        store_b [MAX_WIDTH];
    logic [15:0]        qa_reg, qb_reg;
    logic [COL_W-1:0]   mem_addr;
    logic               mem_we;

    // Frame position decode
    logic [CMP_W-1:0]   wd_eff;
    logic [15:0]        ht_eff;
    logic               last_col, last_row;
    logic               accept, load;
    logic [2:0]         mask_init, low_bit, mask_left;
    logic [1:0]         res_idx;

    always_comb
    begin
        if (cfg_width_reg == 11'd0)
            wd_eff = CMP_W'(1);
        else if (CMP_W'(cfg_width_reg) > CMP_W'(MAX_WIDTH))
            wd_eff = CMP_W'(MAX_WIDTH);
        else
            wd_eff = CMP_W'(cfg_width_reg);
    end
    assign ht_eff   = (cfg_height_reg == 16'd0) ? 16'd1 : cfg_height_reg;
    assign last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= wd_eff;
    assign last_row = ({1'b0, row_reg} + 17'd1) >= {1'b0, ht_eff};

    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign in_stall  = (state_reg != ST_IDLE);
    assign load      = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign mask_init = {last_row && last_col, last_row && (col_reg != '0),
                        row_reg != 16'd0};
    assign low_bit   = mask_reg & (~mask_reg + 3'd1);
    assign mask_left = mask_reg & ~low_bit;
    assign res_idx   = mask_reg[0] ? 2'd0 : (mask_reg[1] ? 2'd1 : 2'd2);

    // Line-store address per sequencer step
    always_comb
    begin
        unique case (state_reg)
            ST_RD1:  mem_addr = col_reg - COL_W'(1);
            ST_RD2:  mem_addr = col_reg + COL_W'(1);
            default: mem_addr = col_reg;
        endcase
    end
    assign mem_we = (state_reg == ST_FIN);

    always_ff @(posedge clk)
    begin
        if (mem_we && !sel_reg)
            store_a[mem_addr] <= cur_reg;
        qa_reg <= store_a[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we && sel_reg)
            store_b[mem_addr] <= cur_reg;
        qb_reg <= store_b[mem_addr];
    end

    // Neighborhood of the pixel under work
    logic [15:0] c_raw, w_raw, e_raw, n_raw, s_raw;

    always_comb
    begin
        case (res_idx)
            2'd0:
            begin
                c_raw = rdx_reg;
                w_raw = (col_reg != '0) ? rdxm_reg : rdx_reg;
                e_raw = last_col ? rdx_reg : rdxp_reg;
                n_raw = (row_reg > 16'd1) ? wrx_reg : rdx_reg;
                s_raw = cur_reg;
            end
            2'd1:
            begin
                c_raw = prev_reg;
                w_raw = (col_reg > COL_W'(1)) ? prev2_reg : prev_reg;
                e_raw = cur_reg;
                n_raw = (row_reg != 16'd0) ? rdxm_reg : prev_reg;
                s_raw = prev_reg;
            end
            default:
            begin
                c_raw = cur_reg;
                w_raw = (col_reg != '0) ? prev_reg : cur_reg;
                e_raw = cur_reg;
                n_raw = (row_reg != 16'd0) ? rdx_reg : cur_reg;
                s_raw = cur_reg;
            end
        endcase
    end

    // Slope operands for the normalizer
    hnm_req_t req;
    hnm_rsp_t rsp;

    always_comb
    begin
        req.start = (state_reg == ST_LAUNCH);
        req.scale = cfg_scale_reg;
        case (vec_reg)
            2'd0:
            begin
                req.p = e_raw;  req.q = c_raw;  req.spacing = cfg_spx_reg;
            end
            2'd1:
            begin
                req.p = c_raw;  req.q = w_raw;  req.spacing = cfg_spx_reg;
            end
            2'd2:
            begin
                req.p = c_raw;  req.q = n_raw;  req.spacing = cfg_spy_reg;
            end
            default:
            begin
                req.p = s_raw;  req.q = c_raw;  req.spacing = cfg_spy_reg;
            end
        endcase
    end

    hnm_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Map a summed component to a byte, clamped to 0..255
    function automatic logic [7:0] to_byte(input logic signed [33:0] s);
        logic [41:0] sx;
        logic [41:0] n;
        sx = 42'(s);
        n  = (sx << 7) - sx + BYTE_BIAS;
        if (n[41])
            to_byte = 8'd0;
        else if (n[40])
            to_byte = 8'd255;
        else
            to_byte = n[39:32];
    endfunction

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_RD0;
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_RD2;
            ST_RD2:    state_next = ST_RD3;
            ST_RD3:    state_next = (mask_init != 3'd0) ? ST_LAUNCH : ST_FIN;
            ST_LAUNCH: state_next = ST_WAIT;
            ST_WAIT:   if (rsp.done) state_next = (vec_reg == 2'd3) ? ST_EMIT : ST_LAUNCH;
            ST_EMIT:   if (load) state_next = (mask_left != 3'd0) ? ST_LAUNCH : ST_FIN;
            ST_FIN:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= 1'b0;
            col_reg       <= '0;
            row_reg       <= 16'd0;
            prev_reg      <= 16'd0;
            prev2_reg     <= 16'd0;
            mask_reg      <= 3'd0;
            vec_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Drop the output beat once taken
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_RD3)
            begin
                mask_reg <= mask_init;
                vec_reg  <= 2'd0;
            end
            if ((state_reg == ST_WAIT) && rsp.done)
                vec_reg <= vec_reg + 2'd1;
            if (load)
            begin
                mask_reg <= mask_left;
                vec_reg  <= 2'd0;
            end
            // Advance position at the end of the item
            if (state_reg == ST_FIN)
            begin
                prev2_reg <= prev_reg;
                prev_reg  <= cur_reg;
                if (last_col)
                begin
                    col_reg <= '0;
                    sel_reg <= ~sel_reg;
                    row_reg <= last_row ? 16'd0 : row_reg + 16'd1;
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // Capture sample, neighbors, sums and the output beat
    always_ff @(posedge clk)
    begin
        if (accept)
            cur_reg <= height_sample;
        if (state_reg == ST_RD1)
        begin
            rdx_reg <= sel_reg ? qa_reg : qb_reg;
            wrx_reg <= sel_reg ? qb_reg : qa_reg;
        end
        if (state_reg == ST_RD2)
            rdxm_reg <= sel_reg ? qa_reg : qb_reg;
        if (state_reg == ST_RD3)
            rdxp_reg <= sel_reg ? qa_reg : qb_reg;
        if ((state_reg == ST_RD3) || load)
        begin
            ax_reg <= 34'sd0;
            ay_reg <= 34'sd0;
            az_reg <= 34'sd0;
        end
        else if ((state_reg == ST_WAIT) && rsp.done)
        begin
            ay_reg <= ay_reg + 34'($unsigned(rsp.up));
            if (vec_reg[1])
                az_reg <= az_reg + 34'(rsp.along);
            else
                ax_reg <= ax_reg + 34'(rsp.along);
        end
        if (load)
        begin
            nx_reg    <= to_byte(-ax_reg);
            ny_reg    <= to_byte(ay_reg);
            nz_reg    <= to_byte(-az_reg);
            ocol_reg  <= (res_idx == 2'd1) ? col_reg - COL_W'(1) : col_reg;
            orow_reg  <= (res_idx == 2'd0) ? row_reg - 16'd1 : row_reg;
            olast_reg <= (mask_left == 3'd0);
            odone_reg <= (res_idx == 2'd2);
        end
    end

    assign out_valid     = out_valid_reg;
    assign normal_x_byte = nx_reg;
    assign normal_y_byte = ny_reg;
    assign normal_z_byte = nz_reg;
    assign pixel_column  = ocol_reg;
    assign pixel_row     = orow_reg;
    assign last_of_run   = olast_reg;
    assign image_done    = odone_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for heightmap_normal_map_top: raster samples in,
// normal bytes with pixel coordinates out, checked against a local normal predictor.
// Depends on hnm_pkg and the RTL of heightmap_normal_map_top.
module tb;
    import hnm_pkg::*;

    localparam int MAXW = 1024;

    typedef struct {
        logic [7:0]  nx;
        logic [7:0]  ny;
        logic [7:0]  nz;
        logic [9:0]  col;
        logic [15:0] row;
        logic        run_end;
        logic        img_done;
    } normal_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic signed [15:0] height_sample = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  normal_x_byte, normal_y_byte, normal_z_byte;
    logic [9:0]  pixel_column;
    logic [15:0] pixel_row;
    logic        last_of_run, image_done;

    heightmap_normal_map_top #(.MAX_WIDTH(MAXW)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .height_sample(height_sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .normal_x_byte(normal_x_byte), .normal_y_byte(normal_y_byte),
        .normal_z_byte(normal_z_byte), .pixel_column(pixel_column),
        .pixel_row(pixel_row), .last_of_run(last_of_run), .image_done(image_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Local copy of the block's state and registers
    logic [15:0] line_mem [2][MAXW];
    int unsigned sel_q, col_q, row_q;
    logic [15:0] prev1_q, prev2_q;
    int unsigned width_r = 1024, height_r = 1024, scale_r = 256;
    int unsigned spx_r = 256, spy_r = 256;

    logic [15:0] samples_todo[$];
    normal_t     normals_due[$];
    int          errors = 0;
    int          items_sent = 0;
    int          normals_seen = 0;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, bit_w;
        r = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w >>= 2;
        while (bit_w != 0)
        begin
            if (v >= r + bit_w)
            begin
                v = v - (r + bit_w);
                r = (r >> 1) + bit_w;
            end
            else
                r >>= 1;
            bit_w >>= 2;
        end
        return r;
    endfunction

    function automatic longint hscale(logic [15:0] raw);
        return longint'($signed(raw)) * longint'(scale_r);
    endfunction

    // Normalize slope (d, spacing) to a Q1.30 unit vector
    task automatic slope_unit(input longint d, input int unsigned sp,
                              output longint along, output longint up);
        longint unsigned a, b, m, len, q;
        a = (d < 0) ? longint'(-d) : d;
        b = longint'((sp == 0) ? 1 : sp) << 8;
        m = (a > b) ? a : b;
        if (m >= (64'd1 << 31))
        begin
            a >>= 1;
            b >>= 1;
        end
        else
        begin
            while (m < (64'd1 << 30))
            begin
                a <<= 1;
                b <<= 1;
                m <<= 1;
            end
        end
        len = isqrt(a * a + b * b);
        q = (a << 30) / len;
        along = (d < 0) ? -longint'(q) : longint'(q);
        up = longint'((b << 30) / len);
    endtask

    function automatic logic [7:0] comp_byte(longint s);
        longint n;
        n = s * 127 + (longint'(128) << 32);
        if (n < 0)
            n = 0;
        n = n >>> 32;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    task automatic queue_normal(longint c, longint w, longint e, longint n,
                                longint s, int unsigned col, int unsigned row,
                                bit done);
        longint x1, y1, x2, y2, z1, y3, z2, y4;
        normal_t r;
        slope_unit(e - c, spx_r, x1, y1);
        slope_unit(c - w, spx_r, x2, y2);
        slope_unit(c - n, spy_r, z1, y3);
        slope_unit(s - c, spy_r, z2, y4);
        r.nx = comp_byte(-(x1 + x2));
        r.ny = comp_byte(y1 + y2 + y3 + y4);
        r.nz = comp_byte(-(z1 + z2));
        r.col = col[9:0];
        r.row = row[15:0];
        r.run_end = 1'b0;
        r.img_done = done;
        normals_due.insert(normals_due.size(), r);
    endtask

    // Advance the local model by one accepted sample
    task automatic predict_normals(logic [15:0] cur);
        int unsigned wd, ht, x, y, wsel, rsel, n0;
        bit last_col, last_row;
        longint sc, c, w, e, n;
        n0 = normals_due.size();
        wd = (width_r < 1) ? 1 : ((width_r > MAXW) ? MAXW : width_r);
        ht = (height_r == 0) ? 1 : height_r;
        x = (col_q >= MAXW) ? MAXW - 1 : col_q;
        y = row_q;
        wsel = sel_q;
        rsel = sel_q ^ 1;
        sc = hscale(cur);
        last_col = (x + 1 >= wd);
        last_row = (y + 1 >= ht);
        if (y > 0)
        begin
            c = hscale(line_mem[rsel][x]);
            w = (x > 0) ? hscale(line_mem[rsel][x - 1]) : c;
            e = last_col ? c : hscale(line_mem[rsel][x + 1]);
            n = (y > 1) ? hscale(line_mem[wsel][x]) : c;
            queue_normal(c, w, e, n, sc, x, y - 1, 1'b0);
        end
        if (last_row)
        begin
            if (x > 0)
            begin
                c = hscale(prev1_q);
                w = (x > 1) ? hscale(prev2_q) : c;
                n = (y > 0) ? hscale(line_mem[rsel][x - 1]) : c;
                queue_normal(c, w, sc, n, c, x - 1, y, 1'b0);
            end
            if (last_col)
            begin
                w = (x > 0) ? hscale(prev1_q) : sc;
                n = (y > 0) ? hscale(line_mem[rsel][x]) : sc;
                queue_normal(sc, w, sc, n, sc, x, y, 1'b1);
            end
        end
        line_mem[wsel][x] = cur;
        prev2_q = prev1_q;
        prev1_q = cur;
        if (last_col)
        begin
            col_q = 0;
            sel_q ^= 1;
            row_q = last_row ? 0 : y + 1;
        end
        else
            col_q = x + 1;
        if (normals_due.size() > n0)
            normals_due[normals_due.size() - 1].run_end = 1'b1;
    endtask

    // Driver: bursts of beats with random gaps, hold while stalled
    int burst_left = 4;
    int gap_left = 0;
    int gap_mode = 0;
    int gap_mode_cnt = 0;

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            predict_normals(height_sample);
            items_sent++;
        end
        if (gap_mode_cnt == 0)
        begin
            gap_mode = $urandom_range(0, 2);
            gap_mode_cnt = $urandom_range(20, 300);
        end
        else
            gap_mode_cnt--;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && in_stall)
            ;
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (samples_todo.size() > 0)
        begin
            in_valid <= 1'b1;
            height_sample <= samples_todo.pop_front();
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap_left = (gap_mode == 0) ? 0 :
                           (gap_mode == 1) ? $urandom_range(0, 3) : $urandom_range(5, 40);
            end
        end
        else
            in_valid <= 1'b0;
    end

    // Monitor: stall pattern of its own and field-by-field compare
    int stall_mode = 0;
    int stall_mode_cnt = 0;

    always @(posedge clk)
    begin
        normal_t exp_n;
        if (out_valid && !out_stall)
        begin
            normals_seen++;
            if (normals_due.size() == 0)
            begin
                $error("unexpected normal beat at column %0d row %0d",
                       pixel_column, pixel_row);
                errors++;
            end
            else
            begin
                exp_n = normals_due.pop_front();
                if (normal_x_byte !== exp_n.nx)
                begin
                    $error("normal_x_byte: expected %0d, got %0d", exp_n.nx, normal_x_byte);
                    errors++;
                end
                if (normal_y_byte !== exp_n.ny)
                begin
                    $error("normal_y_byte: expected %0d, got %0d", exp_n.ny, normal_y_byte);
                    errors++;
                end
                if (normal_z_byte !== exp_n.nz)
                begin
                    $error("normal_z_byte: expected %0d, got %0d", exp_n.nz, normal_z_byte);
                    errors++;
                end
                if (pixel_column !== exp_n.col)
                begin
                    $error("pixel_column: expected %0d, got %0d", exp_n.col, pixel_column);
                    errors++;
                end
                if (pixel_row !== exp_n.row)
                begin
                    $error("pixel_row: expected %0d, got %0d", exp_n.row, pixel_row);
                    errors++;
                end
                if (last_of_run !== exp_n.run_end)
                begin
                    $error("last_of_run: expected %0d, got %0d", exp_n.run_end, last_of_run);
                    errors++;
                end
                if (image_done !== exp_n.img_done)
                begin
                    $error("image_done: expected %0d, got %0d", exp_n.img_done, image_done);
                    errors++;
                end
            end
        end
        if (stall_mode_cnt == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_mode_cnt = $urandom_range(50, 2000);
        end
        else
            stall_mode_cnt--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            default: out_stall <= ($urandom_range(0, 99) < 90);
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  width_r = 32'(val[10:0]);
            REG_IMAGE_HEIGHT: height_r = 32'(val);
            REG_HEIGHT_SCALE: scale_r = 32'(val);
            REG_SPACING_X:    spx_r = 32'(val);
            REG_SPACING_Y:    spy_r = 32'(val);
            default: ;
        endcase
    endtask

    task automatic set_all(int w, int h, int sc, int sx, int sy);
        write_reg(REG_IMAGE_WIDTH, 16'(w));
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        write_reg(REG_HEIGHT_SCALE, 16'(sc));
        write_reg(REG_SPACING_X, 16'(sx));
        write_reg(REG_SPACING_Y, 16'(sy));
    endtask

    // Wait for the stream to drain, then let the block settle
    task automatic drain();
        while (samples_todo.size() > 0 || in_valid || normals_due.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_height();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4, 5: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 511)) - 16'd256;
        endcase
    endfunction

    function automatic int rand_reg16(int lo);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return 65535;
            2: return 256;
            3: return $urandom_range(lo, 1024);
            default: return $urandom_range(lo, 65535);
        endcase
    endfunction

    initial
    begin
        int w, h, imgs;
        sel_q = 0;
        col_q = 0;
        row_q = 0;
        prev1_q = '0;
        prev2_q = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: 3x3 image with extreme heights at the default spacing
        set_all(3, 3, 256, 256, 256);
        samples_todo = '{16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF,
                         16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF};
        drain();
        // Directed: single column, full scale, smallest spacings
        set_all(1, 3, 65535, 1, 1);
        samples_todo = '{16'h7FFF, 16'h8000, 16'h7FFF};
        drain();
        // Directed: zero width and zero height act as one, zero scale
        set_all(0, 0, 0, 65535, 65535);
        samples_todo = '{16'h8000, 16'h5A5A};
        drain();
        // Directed: widest row as a single row, cut short by narrowing
        set_all(2047, 1, 256, 256, 65535);
        for (int i = 0; i < 6; i++)
            samples_todo.insert(samples_todo.size(), rand_height());
        drain();
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        samples_todo.insert(samples_todo.size(), 16'h1234);
        drain();
        // Directed: tallest image, cut short to four rows after three
        set_all(2, 65535, 256, 256, 256);
        for (int i = 0; i < 6; i++)
            samples_todo.insert(samples_todo.size(), rand_height());
        drain();
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        samples_todo = '{16'h0100, 16'hFF00};
        drain();

        // Random images, mostly small, with mixed register settings
        while (items_sent < 470)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            imgs = $urandom_range(1, 2);
            // Keep the total near the planned item count with whole images
            if (w * h * imgs > 480 - items_sent)
            begin
                imgs = 1;
                h = 1;
                if (w > 480 - items_sent)
                    w = 480 - items_sent;
            end
            set_all(w, h, rand_reg16(0), rand_reg16(1), rand_reg16(1));
            for (int i = 0; i < w * h * imgs; i++)
                samples_todo.insert(samples_todo.size(), rand_height());
            drain();
        end

        $display("tb: %0d samples accepted, %0d normals checked over varied sizes",
                 items_sent, normals_seen);
        if (errors == 0 && normals_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule
